/* design/ucs_pkg.sv */
// shared types and constants of the uri component splitter
// no dependencies
`default_nettype none

package ucs_pkg;

  // largest number of results that one input byte can cause
  localparam int NRES = 3;
  localparam int CNTW = $clog2(NRES + 1);

  // command queue between front and back, depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // component tags
  localparam logic [2:0] PART_SCHEME = 3'd0;
  localparam logic [2:0] PART_AUTH   = 3'd1;
  localparam logic [2:0] PART_PATH   = 3'd2;
  localparam logic [2:0] PART_QUERY  = 3'd3;
  localparam logic [2:0] PART_FRAG   = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } ucs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] part;
    logic       is_status;
    logic       uri_valid;
    logic       path_dropped;
    logic       run_last;
  } ucs_out_t;

  // all results of one input byte, item 0 goes out first
  typedef struct packed {
    logic [CNTW-1:0]          cnt;
    ucs_out_t [NRES-1:0]      item;
  } ucs_cmd_t;

endpackage

`default_nettype wire

/* design/ucs_front.sv */
// front part: byte classification, component state and result building
// depends on ucs_pkg
`default_nettype none

module ucs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ucs_pkg::ucs_in_t  in_data_i,
  output ucs_pkg::ucs_cmd_t cmd_o,
  output logic              push_o
);
  import ucs_pkg::*;

  localparam logic [2:0] PH_SCHEME0 = 3'd0;
  localparam logic [2:0] PH_SCHEME1 = 3'd1;
  localparam logic [2:0] PH_COLON   = 3'd2;
  localparam logic [2:0] PH_AUTH    = 3'd3;
  localparam logic [2:0] PH_PATH    = 3'd4;
  localparam logic [2:0] PH_QUERY   = 3'd5;
  localparam logic [2:0] PH_FRAG    = 3'd6;
  localparam logic [2:0] PH_DEAD    = 3'd7;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // working copy of the state plus the results built so far
  typedef struct packed {
    logic [2:0] ph;
    logic [1:0] hc;
    logic [7:0] h1;
    logic       sp;
    logic       df;
    ucs_cmd_t   em;
  } ws_t;

  logic [2:0] ph_q, ph_d;
  logic [1:0] hc_q, hc_d;
  logic [7:0] h1_q, h1_d;
  logic       sp_q, sp_d;
  logic       df_q, df_d;
  ws_t        w;
  logic [7:0] c;
  logic       bad;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) ? (b & 8'hDF) : b;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
  endfunction

  // bit 4 flags a non hex digit
  function automatic logic [4:0] hexv(logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (is_digit(b)) r = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b0, b[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic [2:0] f_part(logic [2:0] ph);
    logic [2:0] p;
    p = PART_FRAG;
    if (ph == PH_AUTH) p = PART_AUTH;
    else if (ph == PH_PATH) p = PART_PATH;
    else if (ph == PH_QUERY) p = PART_QUERY;
    return p;
  endfunction

  function automatic ws_t f_put(ws_t wi, logic [7:0] b, logic [2:0] p, logic st,
                                logic v, logic d);
    ws_t r;
    r = wi;
    r.em.item[wi.em.cnt].out_byte     = b;
    r.em.item[wi.em.cnt].part         = p;
    r.em.item[wi.em.cnt].is_status    = st;
    r.em.item[wi.em.cnt].uri_valid    = v;
    r.em.item[wi.em.cnt].path_dropped = d;
    r.em.item[wi.em.cnt].run_last     = 1'b0;
    r.em.cnt = wi.em.cnt + CNTW'(1);
    return r;
  endfunction

  // path bytes stop once decoding has failed
  function automatic ws_t f_pput(ws_t wi, logic [7:0] b);
    ws_t r;
    r = wi;
    if (!wi.df) r = f_put(wi, b, PART_PATH, 1'b0, 1'b0, 1'b0);
    return r;
  endfunction

  // component end: release held bytes unchanged
  function automatic ws_t f_flush(ws_t wi);
    ws_t r;
    r = wi;
    if (wi.hc != 2'd0) begin
      if (wi.ph == PH_PATH) begin
        r = f_pput(r, CH_PCT);
        if (wi.hc == 2'd2) r = f_pput(r, wi.h1);
      end else if (wi.hc == 2'd2) begin
        r = f_put(r, wi.h1, f_part(wi.ph), 1'b0, 1'b0, 1'b0);
      end
    end
    r.hc = 2'd0;
    return r;
  endfunction

  function automatic ws_t f_comp(ws_t wi, logic [7:0] b);
    ws_t        r;
    logic [4:0] hv;
    logic [4:0] lv;
    r  = wi;
    hv = hexv(wi.h1);
    lv = hexv(b);
    if (wi.ph == PH_PATH) begin
      if (wi.hc == 2'd0) begin
        if (b == CH_PCT) r.hc = 2'd1;
        else r = f_pput(r, b);
      end else if (wi.hc == 2'd1) begin
        r.h1 = b;
        r.hc = 2'd2;
      end else begin
        if (hv[4] || lv[4]) r.df = 1'b1;
        else r = f_pput(r, {hv[3:0], lv[3:0]});
        r.hc = 2'd0;
      end
    end else begin
      if (wi.hc == 2'd0) begin
        r = f_put(r, b, f_part(wi.ph), 1'b0, 1'b0, 1'b0);
        if (b == CH_PCT) r.hc = 2'd1;
      end else if (wi.hc == 2'd1) begin
        r.h1 = b;
        r.hc = 2'd2;
      end else begin
        r = f_put(r, to_upper(wi.h1), f_part(wi.ph), 1'b0, 1'b0, 1'b0);
        r = f_put(r, to_upper(b), f_part(wi.ph), 1'b0, 1'b0, 1'b0);
        r.hc = 2'd0;
      end
    end
    return r;
  endfunction

  function automatic ws_t f_pbyte(ws_t wi, logic [7:0] b);
    ws_t r;
    r = wi;
    if (b == CH_QMARK) begin
      r = f_flush(r);
      r.ph = PH_QUERY;
    end else if (b == CH_HASH) begin
      r = f_flush(r);
      r.ph = PH_FRAG;
    end else begin
      r = f_comp(r, b);
    end
    return r;
  endfunction

  always_comb begin
    c      = in_data_i.in_byte;
    w.ph   = ph_q;
    w.hc   = hc_q;
    w.h1   = h1_q;
    w.sp   = sp_q;
    w.df   = df_q;
    w.em   = '0;
    unique case (ph_q) inside
      PH_SCHEME0, PH_SCHEME1: begin
        if (is_alpha(c) || is_digit(c) || c == CH_MINUS || c == CH_DOT || c == CH_PLUS) begin
          w    = f_put(w, to_lower(c), PART_SCHEME, 1'b0, 1'b0, 1'b0);
          w.ph = PH_SCHEME1;
        end else if (c == CH_COLON && ph_q == PH_SCHEME1) begin
          w.ph = PH_COLON;
        end else begin
          w.ph = PH_DEAD;
        end
      end
      PH_COLON: begin
        if (!w.sp) begin
          if (c == CH_SLASH) begin
            w.sp = 1'b1;
          end else begin
            w.ph = PH_PATH;
            w    = f_pbyte(w, c);
          end
        end else begin
          w.sp = 1'b0;
          if (c == CH_SLASH) begin
            w.ph = PH_AUTH;
          end else begin
            w.ph = PH_PATH;
            w    = f_pput(w, CH_SLASH);
            w    = f_pbyte(w, c);
          end
        end
      end
      PH_AUTH: begin
        if (c == CH_SLASH) begin
          w    = f_flush(w);
          w.ph = PH_PATH;
          w    = f_pbyte(w, c);
        end else if (c == CH_QMARK || c == CH_HASH) begin
          w    = f_flush(w);
          w.ph = PH_DEAD;
        end else begin
          w = f_comp(w, c);
        end
      end
      PH_PATH: w = f_pbyte(w, c);
      PH_QUERY: begin
        if (c == CH_HASH) begin
          w    = f_flush(w);
          w.ph = PH_FRAG;
        end else begin
          w = f_comp(w, c);
        end
      end
      PH_FRAG: w = f_comp(w, c);
      default: ;
    endcase

    // the dead phase marks an invalid uri; so does an end inside the scheme
    bad = (w.ph == PH_DEAD);
    if (in_data_i.in_last) begin
      if (w.ph == PH_SCHEME0 || w.ph == PH_SCHEME1) bad = 1'b1;
      if (w.ph == PH_COLON && w.sp) w = f_pput(w, CH_SLASH);
      if (w.ph == PH_AUTH || w.ph == PH_PATH || w.ph == PH_QUERY || w.ph == PH_FRAG)
        w = f_flush(w);
      w = f_put(w, 8'h00, PART_SCHEME, 1'b1, !bad, w.df);
    end
    if (w.em.cnt != '0) w.em.item[w.em.cnt - CNTW'(1)].run_last = 1'b1;

    ph_d = in_data_i.in_last ? PH_SCHEME0 : w.ph;
    hc_d = in_data_i.in_last ? 2'd0 : w.hc;
    sp_d = in_data_i.in_last ? 1'b0 : w.sp;
    df_d = in_data_i.in_last ? 1'b0 : w.df;
    h1_d = w.h1;
  end

  assign cmd_o  = w.em;
  assign push_o = accept_i && (w.em.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_SCHEME0;
      hc_q <= 2'd0;
      sp_q <= 1'b0;
      df_q <= 1'b0;
    end else if (accept_i) begin
      ph_q <= ph_d;
      hc_q <= hc_d;
      sp_q <= sp_d;
      df_q <= df_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) h1_q <= h1_d;
  end

endmodule

`default_nettype wire

/* design/ucs_queue.sv */
// short command queue between front and back
// depends on ucs_pkg
`default_nettype none

module ucs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ucs_pkg::ucs_cmd_t cmd_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output ucs_pkg::ucs_cmd_t head_o
);
  import ucs_pkg::*;

  ucs_cmd_t         mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QAW:0]     cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + (QAW + 1)'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - (QAW + 1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QAW'(1);
      if (pop_i) rd_q <= rd_q + QAW'(1);
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == (QAW + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

`default_nettype wire

/* design/ucs_back.sv */
// back part: sends the results of each queued command one per transfer
// depends on ucs_pkg
`default_nettype none

module ucs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  ucs_pkg::ucs_cmd_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ucs_pkg::ucs_out_t out_data_o
);
  import ucs_pkg::*;

  logic [CNTW-1:0] idx_q, idx_d;
  logic            ov_q;
  ucs_out_t        out_q;
  logic            load;
  logic            at_end;

  // output register frees up when empty or when its result is taken
  assign load   = !q_empty_i && (!ov_q || !out_stall_i);
  assign at_end = (idx_q == head_i.cnt - CNTW'(1));
  assign pop_o  = load && at_end;

  always_comb begin
    idx_d = idx_q;
    if (load) idx_d = at_end ? '0 : idx_q + CNTW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= head_i.item[idx_q];
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  a_idx_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> (head_i.cnt != '0) && (idx_q < head_i.cnt))
    else $error("result index outside queued command");

endmodule

`default_nettype wire

/* design/uri_component_splitter.sv */
// top level of the streaming uri component splitter
// depends on ucs_pkg, ucs_front, ucs_queue, ucs_back
`default_nettype none

// Splits a URI, one byte per transfer with a last flag, into scheme,
// authority, path, query and fragment bytes, each tagged with its part;
// delimiters are dropped, the scheme is lowercased, path %XX is decoded
// and the two characters after '%' elsewhere are uppercased. After the
// last byte a status result reports validity and path decode failure;
// already sent bytes are never taken back. The front classifies one byte
// per cycle while the command queue is not full and turns it into zero to
// three results, which wait in a four-entry command queue; the back sends
// one result per cycle through an output register while out_stall_i is
// low. The front can take a new byte before the back has sent all results
// of the last one. Input stall rises only while the command queue is full.
module uri_component_splitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ucs_pkg::ucs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ucs_pkg::ucs_out_t out_data_o
);
  import ucs_pkg::*;

  ucs_cmd_t cmd;
  ucs_cmd_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  logic     in_accept;

  // stall depends only on queue fill, never on input valid
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  // classifier and component state, one byte per transfer
  ucs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_data_i (in_data_i),
    .cmd_o     (cmd),
    .push_o    (push)
  );

  // commands with no result are never queued
  ucs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // result sequencer with output register
  ucs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// self-checking testbench for uri_component_splitter
// depends on ucs_pkg and the uri_component_splitter rtl; needs no files or arguments
`timescale 1ns / 100ps

module tb_top;
  import ucs_pkg::*;

  // splitter phases of the predictor
  typedef enum logic [3:0] {
    SP_NO_SCHEME, SP_SCHEME, SP_COLON, SP_AUTH, SP_PATH, SP_QUERY, SP_FRAG, SP_DEAD
  } split_phase_e;

  // one stimulus row: the byte to send, plus an optional hand-typed final result
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    ucs_out_t   want;
  } stim_row_t;

  localparam int NDIR       = 30;
  localparam int NRAND      = 420;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 80;
  localparam int MAX_PRINTS = 100;

  // closing results that can be read off at a glance
  localparam ucs_out_t NO_RES   = ucs_out_t'(0);
  localparam ucs_out_t STAT_BAD = '{out_byte: 8'h00, part: PART_SCHEME, is_status: 1'b1,
                                    uri_valid: 1'b0, path_dropped: 1'b0, run_last: 1'b1};
  localparam ucs_out_t STAT_OK  = '{out_byte: 8'h00, part: PART_SCHEME, is_status: 1'b1,
                                    uri_valid: 1'b1, path_dropped: 1'b0, run_last: 1'b1};
  localparam ucs_out_t STAT_DRP = '{out_byte: 8'h00, part: PART_SCHEME, is_status: 1'b1,
                                    uri_valid: 1'b1, path_dropped: 1'b1, run_last: 1'b1};

  // directed uris, one byte per row
  localparam stim_row_t DIR_TAB [NDIR] = '{
    // empty scheme
    {":",   1'b1, 1'b1, STAT_BAD},
    // byte extremes: bad scheme byte, then a dead byte that is also the last
    {8'hff, 1'b0, 1'b0, NO_RES},
    {8'h00, 1'b1, 1'b1, STAT_BAD},
    // scheme ends without a colon
    {"Z",   1'b1, 1'b1, STAT_BAD},
    // path percent with a non-hex digit drops the path
    {"H",   1'b0, 1'b0, NO_RES},
    {":",   1'b0, 1'b0, NO_RES},
    {"%",   1'b0, 1'b0, NO_RES},
    {"g",   1'b0, 1'b0, NO_RES},
    {".",   1'b1, 1'b1, STAT_DRP},
    // authority ended by '?' with a held percent run
    {"s",   1'b0, 1'b0, NO_RES},
    {":",   1'b0, 1'b0, NO_RES},
    {"/",   1'b0, 1'b0, NO_RES},
    {"/",   1'b0, 1'b0, NO_RES},
    {"%",   1'b0, 1'b0, NO_RES},
    {"b",   1'b0, 1'b0, NO_RES},
    {"?",   1'b1, 1'b1, STAT_BAD},
    // single slash as the final byte
    {"x",   1'b0, 1'b0, NO_RES},
    {":",   1'b0, 1'b0, NO_RES},
    {"/",   1'b1, 1'b1, STAT_OK},
    // path decode, query uppercase, fragment with a held percent at the end
    {"q",   1'b0, 1'b0, NO_RES},
    {":",   1'b0, 1'b0, NO_RES},
    {"%",   1'b0, 1'b0, NO_RES},
    {"7",   1'b0, 1'b0, NO_RES},
    {"e",   1'b0, 1'b0, NO_RES},
    {"?",   1'b0, 1'b0, NO_RES},
    {"%",   1'b0, 1'b0, NO_RES},
    {"a",   1'b0, 1'b0, NO_RES},
    {"b",   1'b0, 1'b0, NO_RES},
    {"#",   1'b0, 1'b0, NO_RES},
    {"%",   1'b1, 1'b1, STAT_OK}
  };

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  ucs_in_t  in_data_i   = ucs_in_t'(0);
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  ucs_out_t out_data_o;

  // stimulus and expected component results
  stim_row_t  stim [$];
  logic [7:0] uri_buf [$];
  ucs_out_t   exp_parts [$];
  ucs_out_t   burst [$];

  int  in_count     = 0;
  int  out_count    = 0;
  int  mismatch_cnt = 0;
  bit  hold_on      = 1'b0;
  bit  held_once    = 1'b0;

  // predictor state
  split_phase_e ph;
  logic [7:0]   held [2];
  logic [1:0]   held_cnt;
  logic         slash_seen;
  logic         uri_bad;
  logic         path_fail;

  uri_component_splitter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_split();
    ph         = SP_NO_SCHEME;
    held_cnt   = 2'd0;
    slash_seen = 1'b0;
    uri_bad    = 1'b0;
    path_fail  = 1'b0;
  endfunction

  function automatic void emit_byte(logic [7:0] b, logic [2:0] p);
    ucs_out_t r;
    r          = ucs_out_t'(0);
    r.out_byte = b;
    r.part     = p;
    burst.push_back(r);
  endfunction

  // path bytes stop for good once a decode has failed
  function automatic void emit_path(logic [7:0] b);
    if (!path_fail) emit_byte(b, PART_PATH);
  endfunction

  function automatic logic [2:0] part_now();
    case (ph)
      SP_AUTH:  return PART_AUTH;
      SP_PATH:  return PART_PATH;
      SP_QUERY: return PART_QUERY;
      default:  return PART_FRAG;
    endcase
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] downcase(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_scheme_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "-" || c == "." || c == "+";
  endfunction

  // component end: held bytes go out unchanged
  function automatic void release_held();
    if (held_cnt != 2'd0) begin
      if (ph == SP_PATH) begin
        emit_path(held[0]);
        if (held_cnt == 2'd2) emit_path(held[1]);
      end else if (held_cnt == 2'd2) begin
        emit_byte(held[1], part_now());
      end
    end
    held_cnt = 2'd0;
  endfunction

  function automatic void take_comp_byte(logic [7:0] c);
    int hi;
    int lo;
    if (ph == SP_PATH) begin
      if (held_cnt == 2'd0) begin
        if (c == "%") begin
          held[0]  = c;
          held_cnt = 2'd1;
        end else begin
          emit_path(c);
        end
      end else if (held_cnt == 2'd1) begin
        held[1]  = c;
        held_cnt = 2'd2;
      end else begin
        hi = hex_nibble(held[1]);
        lo = hex_nibble(c);
        if (hi < 0 || lo < 0) path_fail = 1'b1;
        else emit_path(8'(hi * 16 + lo));
        held_cnt = 2'd0;
      end
    end else begin
      if (held_cnt == 2'd0) begin
        emit_byte(c, part_now());
        if (c == "%") begin
          held[0]  = c;
          held_cnt = 2'd1;
        end
      end else if (held_cnt == 2'd1) begin
        held[1]  = c;
        held_cnt = 2'd2;
      end else begin
        emit_byte(upcase(held[1]), part_now());
        emit_byte(upcase(c), part_now());
        held_cnt = 2'd0;
      end
    end
  endfunction

  function automatic void take_path_byte(logic [7:0] c);
    if (c == "?") begin
      release_held();
      ph = SP_QUERY;
    end else if (c == "#") begin
      release_held();
      ph = SP_FRAG;
    end else begin
      take_comp_byte(c);
    end
  endfunction

  // all component results caused by one accepted byte, left in burst
  function automatic void split_byte(ucs_in_t d);
    logic [7:0] c;
    ucs_out_t   r;
    c = d.in_byte;
    burst.delete();
    case (ph)
      SP_NO_SCHEME, SP_SCHEME: begin
        if (is_scheme_char(c)) begin
          emit_byte(downcase(c), PART_SCHEME);
          ph = SP_SCHEME;
        end else if (c == ":" && ph == SP_SCHEME) begin
          ph = SP_COLON;
        end else begin
          uri_bad = 1'b1;
          ph      = SP_DEAD;
        end
      end
      SP_COLON: begin
        if (!slash_seen) begin
          if (c == "/") begin
            slash_seen = 1'b1;
          end else begin
            ph = SP_PATH;
            take_path_byte(c);
          end
        end else begin
          slash_seen = 1'b0;
          if (c == "/") begin
            ph = SP_AUTH;
          end else begin
            ph = SP_PATH;
            emit_path("/");
            take_path_byte(c);
          end
        end
      end
      SP_AUTH: begin
        if (c == "/") begin
          release_held();
          ph = SP_PATH;
          take_path_byte(c);
        end else if (c == "?" || c == "#") begin
          release_held();
          uri_bad = 1'b1;
          ph      = SP_DEAD;
        end else begin
          take_comp_byte(c);
        end
      end
      SP_PATH: take_path_byte(c);
      SP_QUERY: begin
        if (c == "#") begin
          release_held();
          ph = SP_FRAG;
        end else begin
          take_comp_byte(c);
        end
      end
      SP_FRAG: take_comp_byte(c);
      default: ;
    endcase
    if (d.in_last) begin
      if (ph == SP_NO_SCHEME || ph == SP_SCHEME) uri_bad = 1'b1;
      if (ph == SP_COLON && slash_seen) emit_path("/");
      if (ph == SP_AUTH || ph == SP_PATH || ph == SP_QUERY || ph == SP_FRAG) release_held();
      r              = ucs_out_t'(0);
      r.is_status    = 1'b1;
      r.uri_valid    = !uri_bad;
      r.path_dropped = path_fail;
      burst.push_back(r);
      clear_split();
    end
    if (burst.size() != 0) begin
      r          = burst.pop_back();
      r.run_last = 1'b1;
      burst.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] scheme_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        c = 8'("a" + $urandom_range(0, 25));
        if ($urandom_range(0, 1)) c = upcase(c);
      end
      6, 7:    c = 8'("0" + $urandom_range(0, 9));
      8:       c = $urandom_range(0, 1) ? "-" : ".";
      default: c = "+";
    endcase
    return c;
  endfunction

  // component text, weighted toward percent runs and hex digits
  function automatic logic [7:0] text_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      c = "%";
    end else if (r < 40) begin
      r = $urandom_range(0, 15);
      c = (r < 10) ? 8'("0" + r) : 8'("a" + r - 10);
      if ($urandom_range(0, 1)) c = upcase(c);
    end else if (r < 75) begin
      c = scheme_char();
    end else if (r < 85) begin
      c = "/";
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic void add_text(int n);
    repeat (n) uri_buf.push_back(text_char());
  endfunction

  // one random uri: mostly well formed, some noise, some broken or cut short
  function automatic void gen_uri();
    int kind;
    int n;
    int k;
    stim_row_t row;
    uri_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) uri_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) uri_buf.push_back(scheme_char());
      if (kind == 1) uri_buf.push_back(8'($urandom_range(0, 255)));
      uri_buf.push_back(":");
      if ($urandom_range(0, 1)) begin
        uri_buf.push_back("/");
        uri_buf.push_back("/");
        add_text($urandom_range(0, 5));
        if ($urandom_range(0, 1)) begin
          uri_buf.push_back("/");
          add_text($urandom_range(0, 5));
        end
      end else begin
        add_text($urandom_range(0, 6));
      end
      if ($urandom_range(0, 1)) begin
        uri_buf.push_back("?");
        add_text($urandom_range(0, 5));
      end
      if ($urandom_range(0, 1)) begin
        uri_buf.push_back("#");
        add_text($urandom_range(0, 5));
      end
      if (kind == 2) begin
        n = $urandom_range(1, uri_buf.size());
        while (uri_buf.size() > n) void'(uri_buf.pop_back());
      end
    end
    for (k = 0; k < uri_buf.size(); k++) begin
      row       = stim_row_t'(0);
      row.b     = uri_buf[k];
      row.last  = (k == uri_buf.size() - 1);
      stim.push_back(row);
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(6, 25);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS)
      $display("[%0t] result %0d: %s got %0h expected %0h", $realtime, out_count, what,
               got, want);
  endtask

  initial clear_split();

  // both transfers are sampled at the rising edge, before any driver update lands
  always @(posedge clk_i) begin : monitor
    ucs_out_t want;
    if (rst_ni) begin
      // input transfer: predict what this byte causes
      if (in_valid_i && !in_stall_o) begin
        split_byte(in_data_i);
        if (in_count < stim.size() && stim[in_count].typed) begin
          void'(burst.pop_back());
          burst.push_back(stim[in_count].want);
        end
        foreach (burst[j]) exp_parts.push_back(burst[j]);
        in_count++;
      end
      // output transfer: compare with the oldest expectation, field by field
      if (out_valid_o && !out_stall_i) begin
        if (exp_parts.size() == 0) begin
          report_mismatch("result with nothing expected, byte", out_data_o.out_byte, 8'h00);
        end else begin
          want = exp_parts.pop_front();
          if (out_data_o.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data_o.out_byte, want.out_byte);
          if (out_data_o.part !== want.part)
            report_mismatch("part", 8'(out_data_o.part), 8'(want.part));
          if (out_data_o.is_status !== want.is_status)
            report_mismatch("is_status", 8'(out_data_o.is_status), 8'(want.is_status));
          if (out_data_o.uri_valid !== want.uri_valid)
            report_mismatch("uri_valid", 8'(out_data_o.uri_valid), 8'(want.uri_valid));
          if (out_data_o.path_dropped !== want.path_dropped)
            report_mismatch("path_dropped", 8'(out_data_o.path_dropped),
                            8'(want.path_dropped));
          if (out_data_o.run_last !== want.run_last)
            report_mismatch("run_last", 8'(out_data_o.run_last), 8'(want.run_last));
        end
        out_count++;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stall runs; quiet windows with no stall; one long hold-off so the
  // command queue fills and the input side has to stall
  initial begin : receiver
    int  run_len;
    int  cyc;
    bit  stall_now;
    run_len   = 0;
    cyc       = 0;
    stall_now = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!held_once && in_count >= NDIR + 100) begin
        held_once = 1'b1;
        hold_on   = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_on = 1'b0;
        run_len = 0;
        out_stall_i <= 1'b0;
      end else begin
        if (run_len == 0) begin
          if ((cyc / 200) % 4 == 3 || $urandom_range(0, 99) < 50) begin
            stall_now = 1'b0;
            run_len   = $urandom_range(1, 12);
          end else begin
            stall_now = 1'b1;
            run_len   = idle_len();
          end
        end
        out_stall_i <= stall_now;
        run_len--;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  // ends the run when no transfer happens on either side for too long
  initial begin : watchdog
    int idle_cyc;
    idle_cyc = 0;
    while (idle_cyc < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cyc = 0;
      else idle_cyc++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- sender

  initial begin : sender
    int i;
    int gap;
    foreach (DIR_TAB[j]) stim.push_back(DIR_TAB[j]);
    while (stim.size() < NDIR + NRAND) gen_uri();

    // reset once before the first byte
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < stim.size(); i++) begin
      // no gaps in some stretches and while the receiver holds off
      if (hold_on || (i / 50) % 4 == 3 || $urandom_range(0, 99) < 55) gap = 0;
      else gap = idle_len();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= '{in_byte: stim[i].b, in_last: stim[i].last};
      // hold the payload until the transfer happens
      do @(posedge clk_i); while (in_stall_o);
    end
    in_valid_i <= 1'b0;

    // drain, then a short tail for stray results
    while (exp_parts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (exp_parts.size() != 0)
      report_mismatch("results never seen, count", 8'(exp_parts.size()), 8'h00);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ucs_pkg.sv
design/ucs_front.sv
design/ucs_queue.sv
design/ucs_back.sv
design/uri_component_splitter.sv
tb/sv/tb_top.sv
